FILE: rtl/core/msa_pkg.sv
// ----------------------------------------------------------------------------
// msa_pkg
// Shared types and constants for the min subarray sum block: payload structs,
// controller states and the command/status bundles between control and data.
// ----------------------------------------------------------------------------
package msa_pkg;

   localparam int MaxLen = 1024;
   localparam int AddrW  = $clog2(MaxLen);
   localparam int CntW   = AddrW + 1;
   localparam int ElemW  = 32;
   localparam int SumW   = 48;

   typedef struct packed {
      logic signed [ElemW-1:0] element;
      logic                    last;
   } req_type;

   typedef struct packed {
      logic        found;
      logic [10:0] min_length;
      logic [9:0]  start_index;
      logic [9:0]  end_index;
      logic        overflow;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CHECK,
      ST_SUB,
      ST_EMIT
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic push;     // store element, add to sum, advance right edge
      logic set_ovf;  // element dropped, store full
      logic record;   // window qualifies: keep it if shortest so far
      logic pop;      // subtract left element, advance left edge
      logic emit;     // load result register and clear per-array state
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic room;     // store has space for another element
      logic qualify;  // sum above threshold with a non-empty window
      logic rsp_free; // result register can take a new result
   } status_type;

endpackage

FILE: rtl/core/msa_ctrl.sv
// ----------------------------------------------------------------------------
// msa_ctrl
// Sequencer: takes one element, then alternates check and shrink steps until
// the window no longer qualifies, and hands off the result on the last one.
// ----------------------------------------------------------------------------
module msa_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_last,
   output logic                 req_stall,
   input  msa_pkg::status_type  status,
   output msa_pkg::cmd_type     cmd
);

   msa_pkg::state_type state_ff, state_in;
   logic               last_ff, last_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= msa_pkg::ST_IDLE;
         last_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         last_ff  <= last_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      last_in  = last_ff;
      unique case (state_ff)
         msa_pkg::ST_IDLE: begin
            if (req_valid) begin
               last_in = req_last;
               if (status.room) begin
                  state_in = msa_pkg::ST_CHECK;
               end else if (req_last) begin
                  state_in = msa_pkg::ST_EMIT;
               end
            end
         end
         msa_pkg::ST_CHECK: begin
            if (status.qualify) begin
               state_in = msa_pkg::ST_SUB;
            end else if (last_ff) begin
               state_in = msa_pkg::ST_EMIT;
            end else begin
               state_in = msa_pkg::ST_IDLE;
            end
         end
         msa_pkg::ST_SUB: begin
            state_in = msa_pkg::ST_CHECK;
         end
         msa_pkg::ST_EMIT: begin
            if (status.rsp_free) begin
               state_in = msa_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = msa_pkg::ST_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         msa_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.push    = status.room;
               cmd.set_ovf = !status.room;
            end
         end
         msa_pkg::ST_CHECK: begin
            cmd.record = status.qualify;
         end
         msa_pkg::ST_SUB: begin
            cmd.pop = 1'b1;
         end
         msa_pkg::ST_EMIT: begin
            cmd.emit = status.rsp_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

FILE: rtl/core/msa_dp.sv
// ----------------------------------------------------------------------------
// msa_dp
// Datapath: element store, window sum and edges, best-window record,
// threshold register and the result output register.
// ----------------------------------------------------------------------------
module msa_dp (
   input  logic                              clock,
   input  logic                              reset,
   input  msa_pkg::req_type                  req_data,
   input  logic                              csr_wr_en,
   input  logic signed [msa_pkg::ElemW-1:0]  csr_wr_data,
   input  msa_pkg::cmd_type                  cmd,
   output msa_pkg::status_type               status,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output msa_pkg::rsp_type                  rsp_data
);

   localparam int ExtW = msa_pkg::SumW - msa_pkg::ElemW;

   logic [msa_pkg::ElemW-1:0]        mem [msa_pkg::MaxLen];
   logic [msa_pkg::ElemW-1:0]        rd_data_ff;

   logic signed [msa_pkg::ElemW-1:0] thr_ff;
   logic signed [msa_pkg::SumW-1:0]  sum_ff, sum_in;
   logic [msa_pkg::CntW-1:0]         left_ff, left_in;
   logic [msa_pkg::CntW-1:0]         right_ff, right_in;
   logic [msa_pkg::CntW-1:0]         best_len_ff, best_len_in;
   logic [msa_pkg::AddrW-1:0]        best_start_ff, best_start_in;
   logic [msa_pkg::AddrW-1:0]        best_end_ff, best_end_in;
   logic                             ovf_ff, ovf_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   msa_pkg::rsp_type                 rsp_data_ff, rsp_data_in;

   logic signed [msa_pkg::SumW-1:0]  elem_ext, rd_ext, thr_ext;
   logic [msa_pkg::CntW-1:0]         win_len, right_last;

   assign elem_ext   = {{ExtW{req_data.element[msa_pkg::ElemW-1]}}, req_data.element};
   assign rd_ext     = {{ExtW{rd_data_ff[msa_pkg::ElemW-1]}}, rd_data_ff};
   assign thr_ext    = {{ExtW{thr_ff[msa_pkg::ElemW-1]}}, thr_ff};
   assign win_len    = right_ff - left_ff;
   assign right_last = right_ff - msa_pkg::CntW'(1);

   assign status.room     = (right_ff < msa_pkg::CntW'(msa_pkg::MaxLen));
   assign status.qualify  = (sum_ff > thr_ext) && (left_ff < right_ff);
   assign status.rsp_free = !rsp_valid_ff || !rsp_stall;

   // element store; read port follows the left edge every cycle
   always_ff @(posedge clock) begin
      if (cmd.push) begin
         mem[right_ff[msa_pkg::AddrW-1:0]] <= req_data.element;
      end
      rd_data_ff <= mem[left_ff[msa_pkg::AddrW-1:0]];
   end

   always_comb begin
      sum_in        = sum_ff;
      left_in       = left_ff;
      right_in      = right_ff;
      best_len_in   = best_len_ff;
      best_start_in = best_start_ff;
      best_end_in   = best_end_ff;
      ovf_in        = ovf_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_valid_in  = rsp_valid_ff;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      if (cmd.push) begin
         sum_in   = sum_ff + elem_ext;
         right_in = right_ff + msa_pkg::CntW'(1);
      end
      if (cmd.set_ovf) begin
         ovf_in = 1'b1;
      end
      // only a strictly shorter window replaces the current best
      if (cmd.record && (best_len_ff == '0 || win_len < best_len_ff)) begin
         best_len_in   = win_len;
         best_start_in = left_ff[msa_pkg::AddrW-1:0];
         best_end_in   = right_last[msa_pkg::AddrW-1:0];
      end
      if (cmd.pop) begin
         sum_in  = sum_ff - rd_ext;
         left_in = left_ff + msa_pkg::CntW'(1);
      end
      if (cmd.emit) begin
         rsp_valid_in            = 1'b1;
         rsp_data_in.found       = (best_len_ff != '0);
         rsp_data_in.min_length  = 11'(best_len_ff);
         rsp_data_in.start_index = 10'(best_start_ff);
         rsp_data_in.end_index   = 10'(best_end_ff);
         rsp_data_in.overflow    = ovf_ff;
         sum_in        = '0;
         left_in       = '0;
         right_in      = '0;
         best_len_in   = '0;
         best_start_in = '0;
         best_end_in   = '0;
         ovf_in        = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff        <= '0;
         sum_ff        <= '0;
         left_ff       <= '0;
         right_ff      <= '0;
         best_len_ff   <= '0;
         best_start_ff <= '0;
         best_end_ff   <= '0;
         ovf_ff        <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            thr_ff <= csr_wr_data;
         end
         sum_ff        <= sum_in;
         left_ff       <= left_in;
         right_ff      <= right_in;
         best_len_ff   <= best_len_in;
         best_start_ff <= best_start_in;
         best_end_ff   <= best_end_in;
         ovf_ff        <= ovf_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

FILE: rtl/core/min_subarray_sum_above_core.sv
// ----------------------------------------------------------------------------
// min_subarray_sum_above_core
// Shortest run of consecutive elements whose sum is above a threshold.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one signed element per transfer, with last on the final
//   element of an array. rsp_* carries one result per array: found, the
//   shortest window length and its start and end indices, and overflow when
//   the array held more than 1024 elements (extras are dropped).
//   csr_wr_en/csr_wr_data write the signed threshold; a window qualifies when
//   its sum is strictly greater. Write it only while the block is idle.
// Sequence:
//   Each element is accepted in the idle state, then compared; every element
//   dropped off the left of the window adds a subtract (after the store read)
//   and another compare. Each element leaves the window at most once, and a
//   new element is stalled until the previous one is through.
//   The result register loads in the emit state, once it is free.
// Reset/stall:
//   Synchronous reset clears the window, best record, result valid and sets
//   the threshold to 0; the element store is not cleared. A result held by
//   rsp_stall does not block the next array; only its own result waits.
// ----------------------------------------------------------------------------
module min_subarray_sum_above_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  msa_pkg::req_type                  req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output msa_pkg::rsp_type                  rsp_data,
   input  logic                              csr_wr_en,
   input  logic signed [msa_pkg::ElemW-1:0]  csr_wr_data
);

   msa_pkg::cmd_type    cmd;
   msa_pkg::status_type status;

   msa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_last  (req_data.last),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   msa_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_data    (req_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cmd         (cmd),
      .status      (status),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data)
   );

endmodule

FILE: verif/min_subarray_sum_above_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// min_subarray_sum_above_core_tb
// Self-checking bench for the shortest-window-above-threshold block. A
// directed table covers the field extremes, ties, single-element windows,
// the threshold limits and a store overflow. Random arrays follow under
// several thresholds and idle/stall mixes. Every result transfer is compared
// with a behavioral model of the window scan or with the typed table entry.
// ----------------------------------------------------------------------------
module min_subarray_sum_above_core_tb;

   localparam int QuietLimit = 20000;
   localparam int PhaseItems = 108;
   localparam int NumPhases  = 8;

   typedef enum logic {ROW_DATA, ROW_CFG} row_kind_type;
   typedef enum logic [1:0] {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;

   typedef struct {
      row_kind_type                     kind;
      logic signed [msa_pkg::ElemW-1:0] value;
      int                               count;
      bit                               last;
      bit                               typed;
      msa_pkg::rsp_type                 want;
   } stim_row_type;

   logic                             clock = 1'b0;
   logic                             reset;
   logic                             req_valid;
   logic                             req_stall;
   msa_pkg::req_type                 req_data;
   logic                             rsp_valid;
   logic                             rsp_stall;
   msa_pkg::rsp_type                 rsp_data;
   logic                             csr_wr_en;
   logic signed [msa_pkg::ElemW-1:0] csr_wr_data;

   min_subarray_sum_above_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // window scan state mirrored from the block
   logic signed [msa_pkg::ElemW-1:0] elem_mem [msa_pkg::MaxLen];
   logic signed [msa_pkg::SumW-1:0]  win_sum        = '0;
   int unsigned                      win_left       = 0;
   int unsigned                      win_right      = 0;
   int unsigned                      shortest_len   = 0;
   int unsigned                      shortest_start = 0;
   int unsigned                      shortest_end   = 0;
   bit                               dropped        = 1'b0;
   logic signed [msa_pkg::ElemW-1:0] sum_floor      = '0;

   msa_pkg::rsp_type pending_windows[$];
   int               mismatches = 0;
   int               send_idle_pct = 0;
   int               stall_pct = 0;
   int               quiet_cycles;
   msa_pkg::rsp_type head_want;

   function automatic bit predict_shortest_window(input msa_pkg::req_type item,
                                                  output msa_pkg::rsp_type res);
      logic signed [msa_pkg::ElemW-1:0] e;
      int unsigned r;
      e = item.element;
      res = '0;
      if (win_right < msa_pkg::MaxLen) begin
         r = win_right;
         elem_mem[r] = e;
         win_sum += e;
         win_right = r + 1;
         while (win_sum > sum_floor && win_left <= r) begin
            // strictly shorter only: ties keep the earlier window
            if (shortest_len == 0 || r - win_left + 1 < shortest_len) begin
               shortest_len   = r - win_left + 1;
               shortest_start = win_left;
               shortest_end   = r;
            end
            win_sum -= elem_mem[win_left];
            win_left++;
         end
      end else begin
         dropped = 1'b1;
      end
      if (!item.last) return 1'b0;
      if (shortest_len != 0) begin
         res.found       = 1'b1;
         res.min_length  = 11'(shortest_len);
         res.start_index = 10'(shortest_start);
         res.end_index   = 10'(shortest_end);
      end
      res.overflow = dropped;
      win_sum        = '0;
      win_left       = 0;
      win_right      = 0;
      shortest_len   = 0;
      shortest_start = 0;
      shortest_end   = 0;
      dropped        = 1'b0;
      return 1'b1;
   endfunction

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endfunction

   function automatic msa_pkg::rsp_type mk_want(input bit found, input int len,
                                                input int first, input int lastpos,
                                                input bit ovf);
      msa_pkg::rsp_type w;
      w.found       = found;
      w.min_length  = 11'(len);
      w.start_index = 10'(first);
      w.end_index   = 10'(lastpos);
      w.overflow    = ovf;
      return w;
   endfunction

   function automatic stim_row_type row(input row_kind_type kind,
                                        input logic signed [31:0] value,
                                        input int count, input bit last, input bit typed,
                                        input msa_pkg::rsp_type want);
      stim_row_type s;
      s.kind  = kind;
      s.value = value;
      s.count = count;
      s.last  = last;
      s.typed = typed;
      s.want  = want;
      return s;
   endfunction

   function automatic logic signed [31:0] rand_element();
      int unsigned p;
      p = $urandom_range(99);
      if (p < 55) return int'($urandom_range(40)) - 20;
      if (p < 70) return $urandom;
      if (p < 80) begin
         case ($urandom_range(3))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return 32'sd0;
            default: return -32'sd1;
         endcase
      end
      if (p < 90) return int'($urandom_range(2000)) - 1000;
      return sum_floor + int'($urandom_range(4)) - 2;
   endfunction

   task automatic send_element(input msa_pkg::req_type item, input bit use_typed,
                               input msa_pkg::rsp_type typed_want);
      msa_pkg::rsp_type res;
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (predict_shortest_window(item, res))
         pending_windows.push_back(use_typed ? typed_want : res);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_windows.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_threshold(input logic signed [31:0] value);
      drain();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      sum_floor = value;
      @(posedge clock);
   endtask

   task automatic set_idle(input idle_mode_type mode);
      case (mode)
         IDLE_NONE:     begin send_idle_pct = 0;  stall_pct = 0;  end
         IDLE_SENDER:   begin send_idle_pct = 69; stall_pct = 0;  end
         IDLE_RECEIVER: begin send_idle_pct = 0;  stall_pct = 69; end
         default:       begin send_idle_pct = 32; stall_pct = 32; end
      endcase
   endtask

   function automatic logic signed [31:0] phase_threshold(input int ph);
      case (ph)
         0: return 32'sd0;
         1: return int'($urandom_range(60)) - 30;
         2: return 32'h80000000;
         3: return 32'h7fffffff;
         4: return $urandom;
         5: return int'($urandom_range(10));
         6: return -int'($urandom_range(50));
         default: return int'($urandom_range(200)) - 100;
      endcase
   endfunction

   always @(posedge clock) begin
      rsp_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_windows.size() == 0) begin
            $error("result transfer with no expected window");
            mismatches++;
         end else begin
            head_want = pending_windows.pop_front();
            check_field("found", 32'(head_want.found), 32'(rsp_data.found));
            check_field("min_length", 32'(head_want.min_length),
                        32'(rsp_data.min_length));
            check_field("start_index", 32'(head_want.start_index),
                        32'(rsp_data.start_index));
            check_field("end_index", 32'(head_want.end_index),
                        32'(rsp_data.end_index));
            check_field("overflow", 32'(head_want.overflow), 32'(rsp_data.overflow));
         end
      end
   end

   // watchdog: cycles without any transfer on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QuietLimit) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   initial begin
      stim_row_type     script[$];
      msa_pkg::req_type item;
      int               sent;
      int               len;

      reset        = 1'b1;
      req_valid    = 1'b0;
      req_data     = '0;
      rsp_stall    = 1'b0;
      csr_wr_en    = 1'b0;
      csr_wr_data  = '0;
      quiet_cycles = 0;

      // threshold is 0 out of reset
      script.push_back(row(ROW_DATA, 32'sd5, 1, 1'b1, 1'b1,
                           mk_want(1'b1, 1, 0, 0, 1'b0)));
      script.push_back(row(ROW_DATA, 32'sd0, 1, 1'b1, 1'b1,
                           mk_want(1'b0, 0, 0, 0, 1'b0)));
      script.push_back(row(ROW_DATA, 32'h80000000, 1, 1'b1, 1'b1,
                           mk_want(1'b0, 0, 0, 0, 1'b0)));
      script.push_back(row(ROW_DATA, 32'h7fffffff, 1, 1'b1, 1'b1,
                           mk_want(1'b1, 1, 0, 0, 1'b0)));
      // equal-length later windows do not replace the first
      script.push_back(row(ROW_DATA, 32'h7fffffff, 3, 1'b1, 1'b1,
                           mk_want(1'b1, 1, 0, 0, 1'b0)));
      script.push_back(row(ROW_DATA, -32'sd1, 2, 1'b0, 1'b0, '0));
      script.push_back(row(ROW_DATA, 32'sd3, 1, 1'b1, 1'b0, '0));
      script.push_back(row(ROW_DATA, 32'sd2, 1, 1'b0, 1'b0, '0));
      script.push_back(row(ROW_DATA, -32'sd5, 1, 1'b0, 1'b0, '0));
      script.push_back(row(ROW_DATA, 32'sd4, 1, 1'b1, 1'b0, '0));
      script.push_back(row(ROW_CFG, 32'sd2, 0, 1'b0, 1'b0, '0));
      script.push_back(row(ROW_DATA, 32'sd1, 3, 1'b1, 1'b0, '0));
      script.push_back(row(ROW_DATA, 32'sd1, 3, 1'b0, 1'b0, '0));
      script.push_back(row(ROW_DATA, 32'sd5, 1, 1'b1, 1'b0, '0));
      script.push_back(row(ROW_CFG, 32'h80000000, 0, 1'b0, 1'b0, '0));
      script.push_back(row(ROW_DATA, 32'h80000000, 1, 1'b1, 1'b1,
                           mk_want(1'b0, 0, 0, 0, 1'b0)));
      script.push_back(row(ROW_DATA, 32'h80000001, 1, 1'b1, 1'b1,
                           mk_want(1'b1, 1, 0, 0, 1'b0)));
      script.push_back(row(ROW_CFG, 32'h7fffffff, 0, 1'b0, 1'b0, '0));
      script.push_back(row(ROW_DATA, 32'h7fffffff, 2, 1'b1, 1'b1,
                           mk_want(1'b1, 2, 0, 1, 1'b0)));
      // full-store window, then one dropped element carrying last
      script.push_back(row(ROW_CFG, 32'sd1023, 0, 1'b0, 1'b0, '0));
      script.push_back(row(ROW_DATA, 32'sd1, msa_pkg::MaxLen + 1, 1'b1, 1'b1,
                           mk_want(1'b1, 1024, 0, 1023, 1'b1)));

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (script[i]) begin
         if (script[i].kind == ROW_CFG) begin
            write_threshold(script[i].value);
         end else begin
            for (int k = 0; k < script[i].count; k++) begin
               item.element = script[i].value;
               item.last    = script[i].last && (k == script[i].count - 1);
               send_element(item, script[i].typed && item.last, script[i].want);
            end
         end
      end

      for (int ph = 0; ph < NumPhases; ph++) begin
         write_threshold(phase_threshold(ph));
         set_idle(idle_mode_type'(ph % 4));
         sent = 0;
         while (sent < PhaseItems) begin
            len = ($urandom_range(15) == 0) ? $urandom_range(13, 80) : $urandom_range(1, 12);
            for (int k = 0; k < len; k++) begin
               item.element = rand_element();
               item.last    = (k == len - 1);
               send_element(item, 1'b0, '0);
            end
            sent += len;
         end
      end

      drain();
      repeat (16) @(posedge clock);
      if (mismatches == 0 && pending_windows.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
